>>> rtl/core/ciex_pkg.sv
// Shared types and opcode constants for the instruction execute unit.
package ciex_pkg;

    localparam logic [5:0] OP_MOVW_LD     = 6'd0;
    localparam logic [5:0] OP_MOV         = 6'd1;
    localparam logic [5:0] OP_MOVL_PCREL  = 6'd2;
    localparam logic [5:0] OP_MOVL_LD     = 6'd3;
    localparam logic [5:0] OP_BRA         = 6'd4;
    localparam logic [5:0] OP_JSR         = 6'd5;
    localparam logic [5:0] OP_NOP         = 6'd6;
    localparam logic [5:0] OP_MOVL_PREDEC = 6'd7;
    localparam logic [5:0] OP_RTS         = 6'd8;
    localparam logic [5:0] OP_MOVW_PCREL  = 6'd9;
    localparam logic [5:0] OP_MOVL_POSTINC = 6'd10;
    localparam logic [5:0] OP_STSL_PR     = 6'd11;
    localparam logic [5:0] OP_LDSL_PR     = 6'd12;
    localparam logic [5:0] OP_MOV_IMM     = 6'd13;
    localparam logic [5:0] OP_ADD_IMM     = 6'd14;
    localparam logic [5:0] OP_MOVW_ST     = 6'd15;
    localparam logic [5:0] OP_MOVL_ST     = 6'd16;
    localparam logic [5:0] OP_TST         = 6'd17;
    localparam logic [5:0] OP_CMPEQ_IMM   = 6'd18;
    localparam logic [5:0] OP_CMPEQ       = 6'd19;
    localparam logic [5:0] OP_BF          = 6'd20;
    localparam logic [5:0] OP_BT          = 6'd21;
    localparam logic [5:0] OP_BSR         = 6'd22;
    localparam logic [5:0] OP_JMP         = 6'd23;
    localparam logic [5:0] OP_MOVL_DLD    = 6'd24;
    localparam logic [5:0] OP_MOVL_DST    = 6'd25;
    localparam logic [5:0] OP_MOVW_DLD    = 6'd26;
    localparam logic [5:0] OP_MOVW_DST    = 6'd27;
    localparam logic [5:0] OP_MOVB_LD     = 6'd28;
    localparam logic [5:0] OP_MOVB_ST     = 6'd29;
    localparam logic [5:0] OP_ADD         = 6'd30;
    localparam logic [5:0] OP_SUB         = 6'd31;
    localparam logic [5:0] OP_SHLL        = 6'd32;
    localparam logic [5:0] OP_SHLR        = 6'd33;
    localparam logic [5:0] OP_SHLL2       = 6'd34;
    localparam logic [5:0] OP_SHLR2       = 6'd35;
    localparam logic [5:0] OP_CLRMAC      = 6'd36;
    localparam logic [5:0] OP_CLRT        = 6'd37;
    localparam logic [5:0] OP_SETT        = 6'd38;
    localparam logic [5:0] OP_COUNT       = 6'd39;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNSUP   = 2'd1;
    localparam logic [1:0] ST_ILLSLOT = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    // Classified item as it travels from the front part to the back part.
    typedef struct packed {
        logic        mode;
        logic [5:0]  opcode;
        logic [3:0]  dest_reg;
        logic [3:0]  src_reg;
        logic [11:0] displacement;
        logic [31:0] instr_address;
        logic [31:0] read_data;
        logic        unsupported;
        logic        is_branch;
    } ciex_item_t;

endpackage

>>> rtl/core/cpu_instruction_execute_unit.sv
// Top level of the instruction execute unit: front classifier, queue and executor.
//
// Input channel (in_valid/in_ready) takes either a decoded instruction (mode 0)
// or returning read data (mode 1). Output channel (out_valid/out_ready) gives
// results: a completion, a read request, or a write request that is followed
// by a completion; last marks the final result of an item.
// An accepted item is first registered in the queue, then executed straight
// into the output register, from which its result is presented.
// Throughput: one item per cycle while the receiver takes results and no
// store completion is pending; a store emits two results, a write request
// and then a completion.
// A load finishes only when its data item arrives; instructions arriving
// meanwhile are dropped, as is read data with no load outstanding.
// Reset clears the register file, program counter and all control state.
// When the receiver stalls, the output register holds, the executor stops and
// the queue fills; in_ready falls only once both queue entries are taken.
module cpu_instruction_execute_unit
    import ciex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [5:0]  opcode,
    input  logic [3:0]  dest_reg,
    input  logic [3:0]  src_reg,
    input  logic [11:0] displacement,
    input  logic [31:0] instr_address,
    input  logic [31:0] read_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [31:0] mem_address,
    output logic [31:0] mem_data,
    output logic [1:0]  mem_size,
    output logic [31:0] next_pc,
    output logic        last
);

    logic       q_valid;
    logic       q_pop;
    ciex_item_t q_item;

    ciex_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .opcode(opcode), .dest_reg(dest_reg), .src_reg(src_reg),
        .displacement(displacement), .instr_address(instr_address),
        .read_data(read_data), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    ciex_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .status(status),
        .mem_address(mem_address), .mem_data(mem_data), .mem_size(mem_size),
        .next_pc(next_pc), .last(last)
    );

endmodule

>>> rtl/core/ciex_front.sv
// Front part: accepts input items, classifies them and fills a two-entry queue.
module ciex_front
    import ciex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [5:0]  opcode,
    input  logic [3:0]  dest_reg,
    input  logic [3:0]  src_reg,
    input  logic [11:0] displacement,
    input  logic [31:0] instr_address,
    input  logic [31:0] read_data,
    output logic        q_valid,
    output ciex_item_t  q_item,
    input  logic        q_pop
);

    ciex_item_t  slot_reg [2];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  count_reg, count_next;
    ciex_item_t  item;
    logic        push;

    always_comb
    begin
        item.mode          = mode;
        item.opcode        = opcode;
        item.dest_reg      = dest_reg;
        item.src_reg       = src_reg;
        item.displacement  = displacement;
        item.instr_address = instr_address;
        item.read_data     = read_data;
        item.unsupported   = (opcode >= OP_COUNT);
        case (opcode)
            OP_BRA, OP_JSR, OP_RTS, OP_BF, OP_BT, OP_BSR, OP_JMP: item.is_branch = 1'b1;
            default: item.is_branch = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + {1'b0, push} - {1'b0, (q_pop && q_valid)};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/ciex_back.sv
// Back part: executes queued items against the architectural state and emits results.
module ciex_back
    import ciex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  ciex_item_t  q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [31:0] mem_address,
    output logic [31:0] mem_data,
    output logic [1:0]  mem_size,
    output logic [31:0] next_pc,
    output logic        last
);

    logic [31:0] gpr_reg [16];
    logic [31:0] pc_reg, pc_next;
    logic [31:0] pr_reg, pr_next;
    logic        t_reg, t_next;
    logic [31:0] dtgt_reg, dtgt_next;
    logic        dpend_reg, dpend_next;
    logic        lwait_reg, lwait_next;
    logic [5:0]  popc_reg, popc_next;
    logic [3:0]  pdst_reg, pdst_next;
    logic [3:0]  psrc_reg, psrc_next;

    // Output register (first result) and a second slot for the completion after a store.
    logic        ov_reg;
    logic [1:0]  okind_reg, ost_reg, osize_reg;
    logic [31:0] oaddr_reg, odata_reg, onpc_reg;
    logic        olast_reg;
    logic        second_reg;
    logic [31:0] second_npc_reg;

    logic        we_a, we_b;
    logic [3:0]  wa_a, wa_b;
    logic [31:0] wd_a, wd_b;
    logic        fire, emit, has_second, out_free;
    logic [1:0]  e_kind, e_st, e_size;
    logic [31:0] e_addr, e_data, e_npc;
    logic        e_last;
    logic [31:0] rn_v, rm_v, r0_v, ia4, s8, s12, adv_pc;
    logic        adv_dp;
    logic [5:0]  op;

    assign out_free = !ov_reg || out_ready;
    // A pending store completion occupies the next output slot.
    assign q_pop = q_valid && out_free && !second_reg;
    assign fire  = q_pop;

    assign op   = q_item.opcode;
    assign rn_v = gpr_reg[q_item.dest_reg];
    assign rm_v = gpr_reg[q_item.src_reg];
    assign r0_v = gpr_reg[0];
    assign ia4  = q_item.instr_address + 32'd4;
    assign s8   = {{24{q_item.displacement[7]}}, q_item.displacement[7:0]};
    assign s12  = {{20{q_item.displacement[11]}}, q_item.displacement};
    assign adv_pc = dpend_reg ? dtgt_reg : pc_reg + 32'd2;

    always_comb
    begin
        pc_next = pc_reg; pr_next = pr_reg; t_next = t_reg;
        dtgt_next = dtgt_reg; dpend_next = dpend_reg; lwait_next = lwait_reg;
        popc_next = popc_reg; pdst_next = pdst_reg; psrc_next = psrc_reg;
        we_a = 1'b0; wa_a = q_item.dest_reg; wd_a = '0;
        we_b = 1'b0; wa_b = q_item.src_reg;  wd_b = '0;
        emit = 1'b0; has_second = 1'b0;
        e_kind = KIND_DONE; e_st = ST_OK; e_addr = '0; e_data = '0;
        e_size = SIZE_BYTE; e_npc = '0; e_last = 1'b1;
        adv_dp = 1'b0;
        if (fire)
        begin
            if (q_item.mode)
            begin
                if (lwait_reg)
                begin
                    lwait_next = 1'b0;
                    emit = 1'b1; adv_dp = 1'b1;
                    we_a = 1'b1; wa_a = pdst_reg; wd_a = q_item.read_data;
                    case (popc_reg)
                        OP_MOVW_LD, OP_MOVW_PCREL:
                            wd_a = {{16{q_item.read_data[15]}}, q_item.read_data[15:0]};
                        OP_MOVW_DLD:
                        begin
                            wa_a = 4'd0;
                            wd_a = {{16{q_item.read_data[15]}}, q_item.read_data[15:0]};
                        end
                        OP_MOVB_LD:
                            wd_a = {{24{q_item.read_data[7]}}, q_item.read_data[7:0]};
                        OP_MOVL_POSTINC:
                        begin
                            we_b = (pdst_reg != psrc_reg); wa_b = psrc_reg;
                            wd_b = gpr_reg[psrc_reg] + 32'd4;
                        end
                        OP_LDSL_PR:
                        begin
                            we_a = 1'b0; pr_next = q_item.read_data;
                            we_b = 1'b1; wa_b = psrc_reg;
                            wd_b = gpr_reg[psrc_reg] + 32'd4;
                        end
                        default: ;
                    endcase
                end
            end
            else if (!lwait_reg)
            begin
                emit = 1'b1;
                if (q_item.unsupported)
                begin
                    e_st = ST_UNSUP; e_npc = pc_reg;
                end
                else if (dpend_reg && q_item.is_branch)
                begin
                    e_st = ST_ILLSLOT; e_npc = pc_reg;
                end
                else
                begin
                    adv_dp = 1'b1;
                    e_size = SIZE_LONG;
                    unique case (op)
                        OP_MOVW_LD, OP_MOVL_LD, OP_MOVL_POSTINC, OP_LDSL_PR, OP_MOVB_LD:
                        begin
                            adv_dp = 1'b0; e_kind = KIND_READ; e_addr = rm_v;
                            e_size = (op == OP_MOVW_LD) ? SIZE_WORD :
                                     (op == OP_MOVB_LD) ? SIZE_BYTE : SIZE_LONG;
                        end
                        OP_MOVL_PCREL:
                        begin
                            adv_dp = 1'b0; e_kind = KIND_READ;
                            e_addr = {q_item.instr_address[31:2], 2'b00} + 32'd4
                                     + {18'd0, q_item.displacement, 2'b00};
                        end
                        OP_MOVW_PCREL:
                        begin
                            adv_dp = 1'b0; e_kind = KIND_READ; e_size = SIZE_WORD;
                            e_addr = ia4 + {19'd0, q_item.displacement, 1'b0};
                        end
                        OP_MOVL_DLD:
                        begin
                            adv_dp = 1'b0; e_kind = KIND_READ;
                            e_addr = rm_v + {18'd0, q_item.displacement, 2'b00};
                        end
                        OP_MOVW_DLD:
                        begin
                            adv_dp = 1'b0; e_kind = KIND_READ; e_size = SIZE_WORD;
                            e_addr = rm_v + {19'd0, q_item.displacement, 1'b0};
                        end
                        OP_MOV:
                        begin
                            we_a = 1'b1; wd_a = rm_v;
                        end
                        OP_BRA, OP_BSR, OP_JSR, OP_JMP, OP_RTS:
                        begin
                            adv_dp = 1'b0; dpend_next = 1'b1;
                            pc_next = pc_reg + 32'd2;
                            e_npc = pc_reg + 32'd2;
                            if (op == OP_BRA || op == OP_BSR)
                                dtgt_next = ia4 + {s12[30:0], 1'b0};
                            else if (op == OP_RTS)
                                dtgt_next = pr_reg;
                            else
                                dtgt_next = rn_v;
                            if (op == OP_BSR || op == OP_JSR)
                                pr_next = ia4;
                        end
                        OP_BF, OP_BT:
                        begin
                            adv_dp = 1'b0;
                            if ((op == OP_BT) == t_reg)
                                pc_next = ia4 + {s8[30:0], 1'b0};
                            else
                                pc_next = pc_reg + 32'd2;
                            e_npc = pc_next;
                        end
                        OP_MOVL_PREDEC, OP_STSL_PR:
                        begin
                            we_a = 1'b1; wd_a = rn_v - 32'd4;
                            e_kind = KIND_WRITE; e_addr = rn_v - 32'd4;
                            // Rm equal to Rn stores the decremented value.
                            e_data = (op == OP_STSL_PR) ? pr_reg :
                                     (q_item.src_reg == q_item.dest_reg) ? rn_v - 32'd4 : rm_v;
                        end
                        OP_MOV_IMM:
                        begin
                            we_a = 1'b1; wd_a = s8;
                        end
                        OP_ADD_IMM:
                        begin
                            we_a = 1'b1; wd_a = rn_v + s8;
                        end
                        OP_MOVW_ST:
                        begin
                            e_kind = KIND_WRITE; e_addr = rn_v; e_size = SIZE_WORD;
                            e_data = {16'd0, rm_v[15:0]};
                        end
                        OP_MOVL_ST:
                        begin
                            e_kind = KIND_WRITE; e_addr = rn_v; e_data = rm_v;
                        end
                        OP_MOVL_DST:
                        begin
                            e_kind = KIND_WRITE; e_data = rm_v;
                            e_addr = rn_v + {18'd0, q_item.displacement, 2'b00};
                        end
                        OP_MOVW_DST:
                        begin
                            e_kind = KIND_WRITE; e_size = SIZE_WORD;
                            e_data = {16'd0, r0_v[15:0]};
                            e_addr = rn_v + {19'd0, q_item.displacement, 1'b0};
                        end
                        OP_MOVB_ST:
                        begin
                            e_kind = KIND_WRITE; e_size = SIZE_BYTE; e_addr = rn_v;
                            e_data = {24'd0, rm_v[7:0]};
                        end
                        OP_TST:       t_next = ((rn_v & rm_v) == 32'd0);
                        OP_CMPEQ_IMM: t_next = (r0_v == s8);
                        OP_CMPEQ:     t_next = (rn_v == rm_v);
                        OP_ADD:
                        begin
                            we_a = 1'b1; wd_a = rn_v + rm_v;
                        end
                        OP_SUB:
                        begin
                            we_a = 1'b1; wd_a = rn_v - rm_v;
                        end
                        OP_SHLL:
                        begin
                            t_next = rn_v[31]; we_a = 1'b1; wd_a = {rn_v[30:0], 1'b0};
                        end
                        OP_SHLR:
                        begin
                            t_next = rn_v[0]; we_a = 1'b1; wd_a = {1'b0, rn_v[31:1]};
                        end
                        OP_SHLL2:
                        begin
                            we_a = 1'b1; wd_a = {rn_v[29:0], 2'b00};
                        end
                        OP_SHLR2:
                        begin
                            we_a = 1'b1; wd_a = {2'b00, rn_v[31:2]};
                        end
                        OP_CLRT:   t_next = 1'b0;
                        OP_SETT:   t_next = 1'b1;
                        OP_NOP, OP_CLRMAC: ;
                        default: ;
                    endcase
                    if (e_kind == KIND_READ)
                    begin
                        lwait_next = 1'b1; popc_next = op;
                        pdst_next = q_item.dest_reg; psrc_next = q_item.src_reg;
                    end
                    else if (e_kind == KIND_WRITE)
                    begin
                        has_second = 1'b1; e_last = 1'b0;
                    end
                    else
                    begin
                        e_size = SIZE_BYTE;
                    end
                end
            end
            if (adv_dp)
            begin
                pc_next = adv_pc;
                dpend_next = 1'b0;
                if (!has_second)
                    e_npc = adv_pc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                gpr_reg[i] <= '0;
            pc_reg <= '0; pr_reg <= '0; t_reg <= 1'b0;
            dtgt_reg <= '0; dpend_reg <= 1'b0; lwait_reg <= 1'b0;
            popc_reg <= '0; pdst_reg <= '0; psrc_reg <= '0;
            ov_reg <= 1'b0; second_reg <= 1'b0;
        end
        else
        begin
            if (we_b) gpr_reg[wa_b] <= wd_b;
            if (we_a) gpr_reg[wa_a] <= wd_a;
            pc_reg <= pc_next; pr_reg <= pr_next; t_reg <= t_next;
            dtgt_reg <= dtgt_next; dpend_reg <= dpend_next; lwait_reg <= lwait_next;
            popc_reg <= popc_next; pdst_reg <= pdst_next; psrc_reg <= psrc_next;
            if (out_free)
            begin
                if (second_reg)
                begin
                    ov_reg <= 1'b1; second_reg <= 1'b0;
                end
                else
                begin
                    ov_reg <= emit; second_reg <= has_second;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (second_reg)
            begin
                okind_reg <= KIND_DONE; ost_reg <= ST_OK; oaddr_reg <= '0;
                odata_reg <= '0; osize_reg <= SIZE_BYTE; onpc_reg <= second_npc_reg;
                olast_reg <= 1'b1;
            end
            else
            begin
                okind_reg <= e_kind; ost_reg <= e_st; oaddr_reg <= e_addr;
                odata_reg <= e_data; osize_reg <= e_size; onpc_reg <= e_npc;
                olast_reg <= e_last;
                second_npc_reg <= adv_pc;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign kind        = okind_reg;
    assign status      = ost_reg;
    assign mem_address = oaddr_reg;
    assign mem_data    = odata_reg;
    assign mem_size    = osize_reg;
    assign next_pc     = onpc_reg;
    assign last        = olast_reg;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the instruction execute unit.
module tb
    import ciex_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic [1:0]  mem_size;
        logic [31:0] next_pc;
        logic        last;
    } result_t;

    typedef struct {
        logic        mode;
        logic [5:0]  opcode;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [11:0] disp;
        logic [31:0] ia;
        logic [31:0] rd;
        bit          typed;
        result_t     res;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic [5:0]  opcode = '0;
    logic [3:0]  dest_reg = '0;
    logic [3:0]  src_reg = '0;
    logic [11:0] displacement = '0;
    logic [31:0] instr_address = '0;
    logic [31:0] read_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic [1:0]  mem_size;
    logic [31:0] next_pc;
    logic        last;

    cpu_instruction_execute_unit DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the architectural state.
    logic [31:0] gpr [16];
    logic [31:0] pc_q, pr_q, sr_q, mach_q, macl_q, branch_target;
    bit          branch_pending, load_busy;
    logic [5:0]  load_op;
    logic [3:0]  load_dest, load_src;

    result_t pending_results[$];
    result_t step_results[$];
    int      error_count = 0;
    bit      calm = 0;

    function automatic logic [31:0] sx8(logic [11:0] v);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    function automatic logic [31:0] sx12(logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic result_t done_res(logic [1:0] st, logic [31:0] npc);
        return '{KIND_DONE, st, 32'd0, 32'd0, SIZE_BYTE, npc, 1'b1};
    endfunction

    function automatic void pc_advance();
        if (branch_pending)
        begin
            pc_q = branch_target;
            branch_pending = 0;
        end
        else
            pc_q += 32'd2;
    endfunction

    // Computes the results caused by one accepted item into step_results.
    function automatic void execute_item(stim_t s);
        logic [31:0] addr, data;
        logic [1:0]  size;
        bit          ld, st, tk;
        addr = '0; data = '0; size = SIZE_LONG; ld = 0; st = 0;
        step_results.delete();
        if (s.mode)
        begin
            if (!load_busy)
                return;
            load_busy = 0;
            case (load_op)
                OP_MOVW_LD, OP_MOVW_PCREL: gpr[load_dest] = {{16{s.rd[15]}}, s.rd[15:0]};
                OP_MOVW_DLD: gpr[0] = {{16{s.rd[15]}}, s.rd[15:0]};
                OP_MOVB_LD: gpr[load_dest] = {{24{s.rd[7]}}, s.rd[7:0]};
                OP_MOVL_POSTINC:
                begin
                    if (load_dest != load_src)
                        gpr[load_src] += 32'd4;
                    gpr[load_dest] = s.rd;
                end
                OP_LDSL_PR:
                begin
                    pr_q = s.rd;
                    gpr[load_src] += 32'd4;
                end
                default: gpr[load_dest] = s.rd;
            endcase
            pc_advance();
            step_results.push_back(done_res(ST_OK, pc_q));
            return;
        end
        if (load_busy)
            return;
        if (s.opcode >= OP_COUNT)
        begin
            step_results.push_back(done_res(ST_UNSUP, pc_q));
            return;
        end
        if (branch_pending && s.opcode inside {OP_BRA, OP_JSR, OP_RTS, OP_BF, OP_BT,
                                               OP_BSR, OP_JMP})
        begin
            step_results.push_back(done_res(ST_ILLSLOT, pc_q));
            return;
        end
        case (s.opcode)
            OP_MOVW_LD: begin addr = gpr[s.rm]; size = SIZE_WORD; ld = 1; end
            OP_MOV: gpr[s.rn] = gpr[s.rm];
            OP_MOVL_PCREL: begin addr = (s.ia & ~32'd3) + 32'd4 + s.disp * 4; ld = 1; end
            OP_MOVL_LD, OP_MOVL_POSTINC, OP_LDSL_PR: begin addr = gpr[s.rm]; ld = 1; end
            OP_MOVL_PREDEC:
            begin
                gpr[s.rn] -= 32'd4;
                addr = gpr[s.rn]; data = gpr[s.rm]; st = 1;
            end
            OP_MOVW_PCREL: begin addr = s.ia + 32'd4 + s.disp * 2; size = SIZE_WORD; ld = 1; end
            OP_STSL_PR:
            begin
                gpr[s.rn] -= 32'd4;
                addr = gpr[s.rn]; data = pr_q; st = 1;
            end
            OP_MOV_IMM: gpr[s.rn] = sx8(s.disp);
            OP_ADD_IMM: gpr[s.rn] += sx8(s.disp);
            OP_MOVW_ST:
            begin
                addr = gpr[s.rn]; data = gpr[s.rm] & 32'hFFFF; size = SIZE_WORD; st = 1;
            end
            OP_MOVL_ST: begin addr = gpr[s.rn]; data = gpr[s.rm]; st = 1; end
            OP_TST: sr_q[0] = (gpr[s.rn] & gpr[s.rm]) == 0;
            OP_CMPEQ_IMM: sr_q[0] = gpr[0] == sx8(s.disp);
            OP_CMPEQ: sr_q[0] = gpr[s.rn] == gpr[s.rm];
            OP_BF, OP_BT:
            begin
                tk = (s.opcode == OP_BT) ? sr_q[0] : !sr_q[0];
                pc_q = tk ? s.ia + 32'd4 + (sx8(s.disp) << 1) : pc_q + 32'd2;
                step_results.push_back(done_res(ST_OK, pc_q));
                return;
            end
            OP_BRA, OP_BSR, OP_JSR, OP_JMP, OP_RTS:
            begin
                if (s.opcode == OP_BSR || s.opcode == OP_JSR)
                    pr_q = s.ia + 32'd4;
                if (s.opcode == OP_BRA || s.opcode == OP_BSR)
                    branch_target = s.ia + 32'd4 + (sx12(s.disp) << 1);
                else if (s.opcode == OP_RTS)
                    branch_target = pr_q;
                else
                    branch_target = gpr[s.rn];
                branch_pending = 1;
                pc_q += 32'd2;
                step_results.push_back(done_res(ST_OK, pc_q));
                return;
            end
            OP_MOVL_DLD: begin addr = gpr[s.rm] + s.disp * 4; ld = 1; end
            OP_MOVL_DST: begin addr = gpr[s.rn] + s.disp * 4; data = gpr[s.rm]; st = 1; end
            OP_MOVW_DLD: begin addr = gpr[s.rm] + s.disp * 2; size = SIZE_WORD; ld = 1; end
            OP_MOVW_DST:
            begin
                addr = gpr[s.rn] + s.disp * 2; data = gpr[0] & 32'hFFFF;
                size = SIZE_WORD; st = 1;
            end
            OP_MOVB_LD: begin addr = gpr[s.rm]; size = SIZE_BYTE; ld = 1; end
            OP_MOVB_ST:
            begin
                addr = gpr[s.rn]; data = gpr[s.rm] & 32'hFF; size = SIZE_BYTE; st = 1;
            end
            OP_ADD: gpr[s.rn] += gpr[s.rm];
            OP_SUB: gpr[s.rn] -= gpr[s.rm];
            OP_SHLL: begin sr_q[0] = gpr[s.rn][31]; gpr[s.rn] <<= 1; end
            OP_SHLR: begin sr_q[0] = gpr[s.rn][0]; gpr[s.rn] >>= 1; end
            OP_SHLL2: gpr[s.rn] <<= 2;
            OP_SHLR2: gpr[s.rn] >>= 2;
            OP_CLRMAC: begin mach_q = '0; macl_q = '0; end
            OP_CLRT: sr_q[0] = 1'b0;
            OP_SETT: sr_q[0] = 1'b1;
            default: ;
        endcase
        if (ld)
        begin
            load_busy = 1; load_op = s.opcode; load_dest = s.rn; load_src = s.rm;
            step_results.push_back(result_t'{KIND_READ, ST_OK, addr, 32'd0, size,
                                             32'd0, 1'b1});
            return;
        end
        if (st)
            step_results.push_back(result_t'{KIND_WRITE, ST_OK, addr, data, size,
                                             32'd0, 1'b0});
        pc_advance();
        step_results.push_back(done_res(ST_OK, pc_q));
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result kind", 32'(kind), '1);
            else
            begin
                w = pending_results.pop_front();
                if (kind !== w.kind) report_mismatch("kind", 32'(kind), 32'(w.kind));
                if (status !== w.status)
                    report_mismatch("status", 32'(status), 32'(w.status));
                if (mem_address !== w.mem_address)
                    report_mismatch("mem_address", mem_address, w.mem_address);
                if (mem_data !== w.mem_data) report_mismatch("mem_data", mem_data, w.mem_data);
                if (mem_size !== w.mem_size)
                    report_mismatch("mem_size", 32'(mem_size), 32'(w.mem_size));
                if (next_pc !== w.next_pc) report_mismatch("next_pc", next_pc, w.next_pc);
                if (last !== w.last) report_mismatch("last", 32'(last), 32'(w.last));
            end
        end
    end

    // Receiver: random stall before each result, none while calm is set.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(stim_t s);
        int n;
        n = calm ? 0 : $urandom_range(0, 13);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= s.mode; opcode <= s.opcode; dest_reg <= s.rn; src_reg <= s.rm;
        displacement <= s.disp; instr_address <= s.ia; read_data <= s.rd;
        do @(posedge clk); while (!in_ready);
        execute_item(s);
        if (s.typed)
        begin
            if (step_results.size() == 0)
                report_mismatch("typed row predicted no result", 32'd0, 32'd1);
            pending_results.push_back(s.res);
        end
        else
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endtask

    function automatic stim_t row(logic m, logic [5:0] op, logic [3:0] rn, logic [3:0] rm,
                                  logic [11:0] d, logic [31:0] ia, logic [31:0] rd);
        stim_t s;
        s = '{m, op, rn, rm, d, ia, rd, 0, '0};
        return s;
    endfunction

    function automatic stim_t typed_row(stim_t s, result_t r);
        s.typed = 1; s.res = r;
        return s;
    endfunction

    stim_t directed[$];

    initial
    begin
        stim_t s;
        int p;
        foreach (gpr[i]) gpr[i] = '0;
        pc_q = '0; pr_q = '0; sr_q = '0; mach_q = '0; macl_q = '0; branch_target = '0;
        branch_pending = 0; load_busy = 0; load_op = '0; load_dest = '0; load_src = '0;

        directed.push_back(typed_row(row(1'b0, 6'd63, 4'd15, 4'd15, 12'hFFF, '1, '1),
                                     done_res(ST_UNSUP, 32'd0)));
        directed.push_back(typed_row(row(1'b0, OP_NOP, 4'd0, 4'd0, 12'd0, 32'd0, 32'd0),
                                     done_res(ST_OK, 32'd2)));
        directed.push_back(row(1'b0, OP_MOV_IMM, 4'd1, 4'd0, 12'h080, 32'd4, 32'd0));
        directed.push_back(row(1'b0, OP_MOV_IMM, 4'd2, 4'd0, 12'hF7F, 32'd6, 32'd0));
        directed.push_back(row(1'b0, OP_ADD, 4'd1, 4'd2, 12'd0, 32'd8, 32'd0));
        directed.push_back(row(1'b0, OP_MOVL_PCREL, 4'd3, 4'd0, 12'hFFF, 32'hFFFF_FFFF,
                               32'd0));
        directed.push_back(row(1'b1, 6'd0, 4'd0, 4'd0, 12'd0, 32'd0, 32'hFFFF_FFFF));
        // Read data with no load outstanding is dropped.
        directed.push_back(row(1'b1, 6'd0, 4'd0, 4'd0, 12'd0, 32'd0, 32'h1234_5678));
        directed.push_back(row(1'b0, OP_MOVL_ST, 4'd3, 4'd1, 12'd0, 32'd12, 32'd0));
        directed.push_back(row(1'b0, OP_MOVL_PREDEC, 4'd4, 4'd4, 12'd0, 32'd14, 32'd0));
        directed.push_back(row(1'b0, OP_MOVL_POSTINC, 4'd5, 4'd5, 12'd0, 32'd16, 32'd0));
        // An instruction while a load waits is dropped.
        directed.push_back(row(1'b0, OP_NOP, 4'd0, 4'd0, 12'd0, 32'd18, 32'd0));
        directed.push_back(row(1'b1, 6'd0, 4'd0, 4'd0, 12'd0, 32'd0, 32'h8000_0001));
        directed.push_back(row(1'b0, OP_BRA, 4'd0, 4'd0, 12'h800, 32'd0, 32'd0));
        directed.push_back(typed_row(row(1'b0, OP_BRA, 4'd0, 4'd0, 12'd0, 32'd0, 32'd0),
                                     done_res(ST_ILLSLOT, 32'd18)));
        directed.push_back(row(1'b0, OP_NOP, 4'd0, 4'd0, 12'd0, 32'd0, 32'd0));
        directed.push_back(row(1'b0, OP_BT, 4'd0, 4'd0, 12'h0FF, 32'h100, 32'd0));
        directed.push_back(row(1'b0, OP_SETT, 4'd0, 4'd0, 12'd0, 32'd0, 32'd0));
        directed.push_back(row(1'b0, OP_BT, 4'd0, 4'd0, 12'h07F, 32'h200, 32'd0));
        directed.push_back(row(1'b0, OP_CMPEQ_IMM, 4'd0, 4'd0, 12'h080, 32'd0, 32'd0));
        directed.push_back(row(1'b0, OP_LDSL_PR, 4'd0, 4'd6, 12'd0, 32'd0, 32'd0));
        directed.push_back(row(1'b1, 6'd0, 4'd0, 4'd0, 12'd0, 32'd0, 32'hCAFE_0000));
        directed.push_back(row(1'b0, OP_RTS, 4'd0, 4'd0, 12'd0, 32'd0, 32'd0));
        directed.push_back(row(1'b0, OP_JSR, 4'd1, 4'd0, 12'd0, 32'd0, 32'd0));
        directed.push_back(row(1'b0, OP_MOVB_LD, 4'd7, 4'd1, 12'd0, 32'd0, 32'd0));
        directed.push_back(row(1'b1, 6'd0, 4'd0, 4'd0, 12'd0, 32'd0, 32'h0000_0080));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_item(directed[i]);

        for (int i = 0; i < 1200; i++)
        begin
            if (i % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            p = $urandom_range(0, 99);
            s = row(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    12'($urandom_range(0, 4095)), $urandom, $urandom);
            // Mostly well-formed traffic: answer loads, otherwise send valid opcodes.
            if (p >= 8)
            begin
                s.mode = load_busy;
                if (!load_busy && p >= 14)
                    s.opcode = 6'($urandom_range(0, OP_COUNT - 1));
                else if (load_busy && p < 20)
                    s.mode = 0;
            end
            send_item(s);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ciex_pkg.sv
rtl/core/ciex_front.sv
rtl/core/ciex_back.sv
rtl/core/cpu_instruction_execute_unit.sv
tb/tb.sv
